/* src/assert_macros.svh */
// Assertion macros for the RTL files of the key edge and auto-repeat block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

/* src/kear_pkg.sv */
// Types and constants of the key edge and auto-repeat block.
`default_nettype none

package kear_pkg;

    // Key set geometry, bit 0 is A and the top bit is L
    localparam int unsigned KEY_COUNT = 10;
    localparam int unsigned BIT_A     = 0;
    localparam int unsigned BIT_L     = 9;

    localparam int unsigned DELAY_W = 8;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    typedef logic [KEY_COUNT-1:0] t_keys;
    typedef logic [DELAY_W-1:0]   t_delay;
    typedef logic [MODE_W-1:0]    t_mode;

    // Button mode that folds L onto A
    localparam t_mode MODE_REMAP_L_TO_A = 2'd2;

    // Register map, word index
    typedef enum logic [1:0] {
        REG_START_DELAY    = 2'd0,
        REG_CONTINUE_DELAY = 2'd1,
        REG_BUTTON_MODE    = 2'd2,
        REG_WATCHED_MASK   = 2'd3
    } t_reg_idx;

    // Reset values of the registers
    localparam t_delay START_DELAY_RST    = 8'd40;
    localparam t_delay CONTINUE_DELAY_RST = 8'd5;

    // One result request
    typedef struct packed {
        t_keys new_raw;
        t_keys new_keys;
        t_keys held_raw;
        t_keys held_keys;
        t_keys new_and_repeated;
        logic  watched_pressed;
    } t_result;

endpackage

`default_nettype wire

/* src/key_edge_and_auto_repeat_top.sv */
// Top level of the key edge and auto-repeat block: key state, repeat timer and output buffer.
`default_nettype none
`include "assert_macros.svh"

// Takes one frame sample of active-low key lines per request and returns one result per
// request: the newly pressed keys, the held set, their L-to-A remapped forms, the new keys
// merged with typematic repeats and a sticky flag for watched keys. A request is accepted
// whenever the skid entry is free, at one request per cycle while o_in_stall is low, a rate
// set by the single read-modify-write of the held set, repeat countdown and watched flag
// registers. A two-entry output buffer lets one further request in while a result waits to
// be taken; o_in_stall rises only when both are full. Registers are to be written through
// the APB-style port only while the block is idle; the block itself does not enforce this.
module key_edge_and_auto_repeat_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [kear_pkg::ADDR_W-1:0]   paddr,
    input  wire [kear_pkg::DATA_W-1:0]   pwdata,
    output logic [kear_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // input channel
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire [kear_pkg::KEY_COUNT-1:0] i_key_lines,
    input  wire                          i_clear_watched,
    // output channel
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [kear_pkg::KEY_COUNT-1:0] o_new_raw,
    output logic [kear_pkg::KEY_COUNT-1:0] o_new_keys,
    output logic [kear_pkg::KEY_COUNT-1:0] o_held_raw,
    output logic [kear_pkg::KEY_COUNT-1:0] o_held_keys,
    output logic [kear_pkg::KEY_COUNT-1:0] o_new_and_repeated,
    output logic                         o_watched_pressed
);

    // Configuration registers
    kear_pkg::t_delay r_start_delay;
    kear_pkg::t_delay r_continue_delay;
    kear_pkg::t_mode  r_button_mode;
    kear_pkg::t_keys  r_watched_mask;

    // Frame state
    kear_pkg::t_keys  r_prev_held;
    kear_pkg::t_delay r_repeat_count;
    logic             r_watched_flag;

    kear_pkg::t_keys  n_prev_held;
    kear_pkg::t_delay n_repeat_count;
    logic             n_watched_flag;

    // Output buffer
    kear_pkg::t_result r_out;
    logic              r_out_valid;
    kear_pkg::t_result r_skid;
    logic              r_skid_valid;

    kear_pkg::t_result n_result;
    kear_pkg::t_reg_idx w_idx;
    kear_pkg::t_delay   w_dec;
    logic               w_cfg_wr;
    logic               w_in_acc;
    logic               w_out_take;

    assign pready   = 1'b1;
    assign w_idx    = kear_pkg::t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delay    <= kear_pkg::START_DELAY_RST;
            r_continue_delay <= kear_pkg::CONTINUE_DELAY_RST;
            r_button_mode    <= '0;
            r_watched_mask   <= '0;
        end else if (w_cfg_wr) begin
            case (w_idx)
                kear_pkg::REG_START_DELAY:    r_start_delay    <= pwdata[kear_pkg::DELAY_W-1:0];
                kear_pkg::REG_CONTINUE_DELAY: r_continue_delay <= pwdata[kear_pkg::DELAY_W-1:0];
                kear_pkg::REG_BUTTON_MODE:    r_button_mode    <= pwdata[kear_pkg::MODE_W-1:0];
                kear_pkg::REG_WATCHED_MASK:   r_watched_mask   <= pwdata[kear_pkg::KEY_COUNT-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back, zero extended
    always_comb begin
        case (w_idx)
            kear_pkg::REG_START_DELAY:
                prdata = kear_pkg::DATA_W'(r_start_delay);
            kear_pkg::REG_CONTINUE_DELAY:
                prdata = kear_pkg::DATA_W'(r_continue_delay);
            kear_pkg::REG_BUTTON_MODE:
                prdata = kear_pkg::DATA_W'(r_button_mode);
            kear_pkg::REG_WATCHED_MASK:
                prdata = kear_pkg::DATA_W'(r_watched_mask);
            default:
                prdata = '0;
        endcase
    end

    // Handshake: new request goes in unless the skid entry is occupied
    assign o_in_stall = r_skid_valid;
    assign w_in_acc   = i_in_valid && !r_skid_valid;
    assign w_out_take = r_out_valid && !i_out_stall;

    // Frame update: edges, repeat timer, remap and watched flag
    always_comb begin
        kear_pkg::t_keys held;
        kear_pkg::t_keys fresh;
        kear_pkg::t_keys rep;
        kear_pkg::t_keys fresh_m;
        kear_pkg::t_keys held_m;
        logic            flag;

        held  = ~i_key_lines;
        fresh = held & ~r_prev_held;
        rep   = fresh;
        w_dec = r_repeat_count - kear_pkg::DELAY_W'(1);

        // same non-empty set still held: count down, repeat on zero
        if ((held != '0) && (held == r_prev_held)) begin
            if (w_dec == '0) begin
                rep            = held;
                n_repeat_count = r_continue_delay;
            end else begin
                n_repeat_count = w_dec;
            end
        end else begin
            n_repeat_count = r_start_delay;
        end

        fresh_m = fresh;
        held_m  = held;
        if (r_button_mode == kear_pkg::MODE_REMAP_L_TO_A) begin
            fresh_m[kear_pkg::BIT_A] = fresh[kear_pkg::BIT_A] | fresh[kear_pkg::BIT_L];
            held_m[kear_pkg::BIT_A]  = held[kear_pkg::BIT_A] | held[kear_pkg::BIT_L];
        end

        // clear goes first, a watched press in the same frame wins
        flag           = r_watched_flag && !i_clear_watched;
        n_watched_flag = flag || ((fresh_m & r_watched_mask) != '0);
        n_prev_held    = held;

        n_result.new_raw          = fresh;
        n_result.new_keys         = fresh_m;
        n_result.held_raw         = held;
        n_result.held_keys        = held_m;
        n_result.new_and_repeated = rep;
        n_result.watched_pressed  = n_watched_flag;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_held    <= '0;
            r_repeat_count <= '0;
            r_watched_flag <= 1'b0;
        end else if (w_in_acc) begin
            r_prev_held    <= n_prev_held;
            r_repeat_count <= n_repeat_count;
            r_watched_flag <= n_watched_flag;
        end
    end

    // Output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_in_acc;
            end
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_acc) begin
                r_out <= n_result;
            end
        end else if (w_in_acc) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_new_raw          = r_out.new_raw;
    assign o_new_keys         = r_out.new_keys;
    assign o_held_raw         = r_out.held_raw;
    assign o_held_keys        = r_out.held_keys;
    assign o_new_and_repeated = r_out.new_and_repeated;
    assign o_watched_pressed  = r_out.watched_pressed;

    // Checks
    `ASSERT_NEVER(a_skid_without_out, i_clk, i_rst_n, r_skid_valid && !r_out_valid, "skid entry full while output register empty")
    `ASSERT_CLK(a_stalled_req_to_skid, i_clk, i_rst_n, w_in_acc && r_out_valid && i_out_stall |=> r_skid_valid, "request lost while output stalled")
    `ASSERT_CLK(a_timer_reload, i_clk, i_rst_n, w_in_acc && (n_prev_held != r_prev_held) |=> r_repeat_count == $past(r_start_delay), "repeat timer not reloaded on changed key set")

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the key edge and auto-repeat block: random and directed frames.
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        kear_pkg::t_keys lines;
        logic            clr;
    } t_frame;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // configuration port
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [kear_pkg::ADDR_W-1:0] paddr   = '0;
    logic [kear_pkg::DATA_W-1:0] pwdata  = '0;
    logic [kear_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    // request and result channels
    logic            in_valid      = 1'b0;
    logic            in_stall;
    kear_pkg::t_keys key_lines     = '1;
    logic            clear_watched = 1'b0;
    logic            out_valid;
    logic            out_stall     = 1'b0;
    kear_pkg::t_keys new_raw, new_keys, held_raw, held_keys, new_and_repeated;
    logic            watched_pressed;

    key_edge_and_auto_repeat_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_key_lines        (key_lines),
        .i_clear_watched    (clear_watched),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_new_raw          (new_raw),
        .o_new_keys         (new_keys),
        .o_held_raw         (held_raw),
        .o_held_keys        (held_keys),
        .o_new_and_repeated (new_and_repeated),
        .o_watched_pressed  (watched_pressed)
    );

    // pending frames and expected results
    t_frame            frame_q[$];
    kear_pkg::t_result result_q[$];

    // bench copy of the registers and key state
    kear_pkg::t_delay cfg_start     = kear_pkg::START_DELAY_RST;
    kear_pkg::t_delay cfg_continue  = kear_pkg::CONTINUE_DELAY_RST;
    kear_pkg::t_mode  cfg_mode      = '0;
    kear_pkg::t_keys  cfg_mask      = '0;
    kear_pkg::t_keys  exp_held_prev = '0;
    kear_pkg::t_delay exp_countdown = '0;
    logic             exp_watched   = 1'b0;

    bit idle_on       = 1'b1;
    int hold_requests = 0;
    int holds_served  = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int n_fail        = 0;
    int n_accepted    = 0;
    int n_results     = 0;
    int n_repeats     = 0;
    int n_remapped    = 0;
    int n_watched     = 0;

    // L also raises A in remap mode
    function automatic kear_pkg::t_keys fold_l_onto_a(kear_pkg::t_keys k);
        if (cfg_mode == kear_pkg::MODE_REMAP_L_TO_A && k[kear_pkg::BIT_L])
            k[kear_pkg::BIT_A] = 1'b1;
        return k;
    endfunction

    // expected result of one frame, advancing the bench key state
    function automatic kear_pkg::t_result predict_frame(kear_pkg::t_keys lines, logic clr);
        kear_pkg::t_result r;
        kear_pkg::t_keys   held_now, fresh, rep;
        held_now = ~lines;
        fresh    = held_now & ~exp_held_prev;
        rep      = fresh;
        if (clr)
            exp_watched = 1'b0;
        // countdown runs only while the same non-empty raw set is held
        if (held_now != '0 && held_now == exp_held_prev) begin
            exp_countdown = exp_countdown - 1'b1;
            if (exp_countdown == '0) begin
                rep           = held_now;
                exp_countdown = cfg_continue;
            end
        end else begin
            exp_countdown = cfg_start;
        end
        exp_held_prev      = held_now;
        r.new_raw          = fresh;
        r.new_keys         = fold_l_onto_a(fresh);
        r.held_raw         = held_now;
        r.held_keys        = fold_l_onto_a(held_now);
        r.new_and_repeated = rep;
        if ((r.new_keys & cfg_mask) != '0)
            exp_watched = 1'b1;
        r.watched_pressed = exp_watched;
        return r;
    endfunction

    task automatic compare_field(string name, kear_pkg::t_keys want, kear_pkg::t_keys got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    // driver: offers queued frames, holds a stalled request, idles in bursts
    always @(posedge i_clk) begin
        t_frame nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                result_q.push_back(predict_frame(key_lines, clear_watched));
                n_accepted++;
            end
            if (in_valid && in_stall) begin
                // request held until taken
            end else if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (frame_q.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
                in_valid <= 1'b0;
                gap_left <= $urandom_range(0, 16);
            end else if (frame_q.size() != 0) begin
                nxt           = frame_q.pop_front();
                in_valid      <= 1'b1;
                key_lines     <= nxt.lines;
                clear_watched <= nxt.clr;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks results in order, stalls in bursts or for a long hold
    always @(posedge i_clk) begin
        kear_pkg::t_result want;
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                n_results++;
                if (result_q.size() == 0) begin
                    $error("result with no request outstanding");
                    n_fail++;
                end else begin
                    want = result_q.pop_front();
                    compare_field("new_raw", want.new_raw, new_raw);
                    compare_field("new_keys", want.new_keys, new_keys);
                    compare_field("held_raw", want.held_raw, held_raw);
                    compare_field("held_keys", want.held_keys, held_keys);
                    compare_field("new_and_repeated", want.new_and_repeated,
                                  new_and_repeated);
                    compare_field("watched_pressed",
                                  kear_pkg::t_keys'(want.watched_pressed),
                                  kear_pkg::t_keys'(watched_pressed));
                    if (want.new_and_repeated != want.new_raw)
                        n_repeats++;
                    if (want.held_keys != want.held_raw)
                        n_remapped++;
                    if (want.watched_pressed)
                        n_watched++;
                end
            end
            if (holds_served != hold_requests) begin
                holds_served <= holds_served + 1;
                stall_left   <= 150;
                out_stall    <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(0, 16);
                out_stall  <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // register write: setup then access cycle, bench copy follows
    task automatic apb_write(kear_pkg::t_reg_idx idx, logic [kear_pkg::DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            kear_pkg::REG_START_DELAY:    cfg_start    = value[kear_pkg::DELAY_W-1:0];
            kear_pkg::REG_CONTINUE_DELAY: cfg_continue = value[kear_pkg::DELAY_W-1:0];
            kear_pkg::REG_BUTTON_MODE:    cfg_mode     = value[kear_pkg::MODE_W-1:0];
            kear_pkg::REG_WATCHED_MASK:   cfg_mask     = value[kear_pkg::KEY_COUNT-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int start_d, int cont_d, int mode, int mask);
        apb_write(kear_pkg::REG_START_DELAY, start_d);
        apb_write(kear_pkg::REG_CONTINUE_DELAY, cont_d);
        apb_write(kear_pkg::REG_BUTTON_MODE, mode);
        apb_write(kear_pkg::REG_WATCHED_MASK, mask);
    endtask

    // pressed set given active high, lines sent active low
    task automatic press(kear_pkg::t_keys keys, logic clr = 1'b0);
        t_frame f;
        f.lines = ~keys;
        f.clr   = clr;
        frame_q.push_back(f);
    endtask

    task automatic hold_for(kear_pkg::t_keys keys, int frames_n);
        for (int i = 0; i < frames_n; i++)
            press(keys, $urandom_range(0, 9) == 0);
    endtask

    // mostly a few keys, sometimes L alone or any pattern
    function automatic kear_pkg::t_keys pick_keys();
        kear_pkg::t_keys k;
        int              sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            k = '0;
            k[kear_pkg::BIT_L] = 1'b1;
        end else if (sel < 3) begin
            k = kear_pkg::t_keys'($urandom_range(0, (1 << kear_pkg::KEY_COUNT) - 1));
        end else begin
            k = '0;
            repeat ($urandom_range(1, 3))
                k[$urandom_range(0, kear_pkg::KEY_COUNT - 1)] = 1'b1;
        end
        return k;
    endfunction

    // held runs with random content, plus noise and releases
    task automatic random_mix(int n, int max_run);
        int queued;
        int sel;
        int run;
        queued = 0;
        while (queued < n) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                run = $urandom_range(1, max_run);
                hold_for(pick_keys(), run);
            end else if (sel < 9) begin
                run = $urandom_range(1, 4);
                repeat (run)
                    press(kear_pkg::t_keys'($urandom_range(0, (1 << kear_pkg::KEY_COUNT) - 1)),
                          $urandom_range(0, 3) == 0);
            end else begin
                run = $urandom_range(1, 3);
                repeat (run) press('0, 1'($urandom_range(0, 1)));
            end
            queued += run;
        end
    endtask

    // sender pause until every result is back, sampled once the edge has settled
    task automatic drain();
        while (frame_q.size() != 0 || in_valid || result_q.size() != 0)
            @(negedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: releases, full press, L without remap, lone clear
        press('0);
        press('1);
        press('1);
        press('0);
        press(10'h001);
        press(10'h200);
        press(10'h201);
        press(10'h201, 1'b1);
        press('0, 1'b1);
        random_mix(100, 60);
        drain();

        // shortest delays, remap on, every key watched
        set_config(1, 1, kear_pkg::MODE_REMAP_L_TO_A, 10'h3FF);
        press(10'h200);
        press(10'h200);
        press(10'h200);
        press(10'h200, 1'b1);
        press(10'h201, 1'b1);
        press('0, 1'b1);
        press(10'h200, 1'b1);
        press('1);
        press('0);
        random_mix(220, 8);
        drain();

        // longest nonzero delays, mode 3 leaves L alone
        set_config(255, 255, 3, 10'h201);
        press(10'h200);
        hold_for(10'h081, 300);
        random_mix(100, 20);
        drain();

        // delays written as zero give a 256 frame interval
        set_config(0, 0, 1, 10'h00F);
        hold_for(10'h3FF, 270);
        random_mix(100, 10);
        drain();

        // random settings with a long receiver hold while the sender keeps offering
        for (int p = 0; p < 4; p++) begin
            set_config($urandom_range(1, 8), $urandom_range(1, 4), $urandom_range(0, 3),
                       $urandom_range(0, (1 << kear_pkg::KEY_COUNT) - 1));
            random_mix(120, 16);
            if (p == 1)
                hold_requests++;
            drain();
        end

        // last stretch at full rate, no idling on either side
        idle_on = 1'b0;
        set_config(2, 1, kear_pkg::MODE_REMAP_L_TO_A,
                   $urandom_range(0, (1 << kear_pkg::KEY_COUNT) - 1));
        random_mix(200, 10);
        drain();
        repeat (5) @(posedge i_clk);

        if (result_q.size() != 0) begin
            $error("%0d results never arrived", result_q.size());
            n_fail++;
        end
        $display("Run covered %0d frames over 9 register settings, %0d results checked,",
                 n_accepted, n_results);
        $display("%0d with repeats, %0d with L folded onto A, %0d with the watched flag set.",
                 n_repeats, n_remapped, n_watched);
        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
